>>> hdl/egcd_pkg.sv
package egcd_pkg;

  localparam int WIDTH = 32;
  localparam int CW    = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CW-1:0]    coef_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Handshake between the sequencer and the shared divide unit.
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

>>> hdl/egcd_divmac.sv
module egcd_divmac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  egcd_pkg::word_t     dividend_i,
  input  egcd_pkg::word_t     divisor_i,
  input  egcd_pkg::coef_t     coef_hi_i,
  input  egcd_pkg::coef_t     coef_lo_i,
  output logic                done_o,
  output egcd_pkg::word_t     rem_o,
  output egcd_pkg::coef_t     prod_hi_o,
  output egcd_pkg::coef_t     prod_lo_o
);
  import egcd_pkg::*;

  logic          run_q;
  logic          done_q;
  cnt_t          cnt_q;
  word_t         rem_q;
  word_t         dvd_q;
  coef_t         acc_hi_q;
  coef_t         acc_lo_q;

  logic [WIDTH:0] shifted;
  logic [WIDTH:0] diff;
  logic           ge;

  // One restoring division bit per cycle. The quotient bit also drives a
  // shift-and-add accumulation of quotient times each coefficient.
  assign shifted = {rem_q, dvd_q[WIDTH-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = (shifted >= {1'b0, divisor_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= cnt_t'(WIDTH - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - cnt_t'(1);
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q    <= '0;
      dvd_q    <= dividend_i;
      acc_hi_q <= '0;
      acc_lo_q <= '0;
    end else if (run_q) begin
      rem_q    <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd_q    <= {dvd_q[WIDTH-2:0], 1'b0};
      acc_hi_q <= {acc_hi_q[CW-2:0], 1'b0} + (ge ? coef_hi_i : '0);
      acc_lo_q <= {acc_lo_q[CW-2:0], 1'b0} + (ge ? coef_lo_i : '0);
    end
  end

  assign done_o    = done_q;
  assign rem_o     = rem_q;
  assign prod_hi_o = acc_hi_q;
  assign prod_lo_o = acc_lo_q;

endmodule

>>> hdl/extended_gcd_modular_inverse_core.sv
// Channel  Direction  Handshake           Ports
// input    in         start, busy         first_value_i, second_value_i
// result   out        valid_o (strobe)    divisor_o, first_coefficient_o,
//                                         second_coefficient_o
//
// A transaction is accepted when start is high and busy is low.
// Each Euclid step runs one division in the shared bit-serial divide unit.
// The result strobe is high for exactly one cycle; the receiver cannot stall.
// busy drops in the cycle the strobe rises, so a new transaction may start then.
// Reset is asynchronous and active low and returns the sequencer to idle.
module extended_gcd_modular_inverse_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  egcd_pkg::word_t           first_value_i,
  input  egcd_pkg::word_t           second_value_i,
  output logic                      valid_o,
  output egcd_pkg::word_t           divisor_o,
  output egcd_pkg::word_t           first_coefficient_o,
  output logic signed [egcd_pkg::CW-1:0] second_coefficient_o
);
  import egcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e    state_q;
  logic      valid_q;
  logic      swapped_q;
  word_t     hi_q;
  word_t     lo_q;
  word_t     b_q;
  coef_t     hp_q, hc_q, lp_q, lc_q;
  word_t     g_q;
  word_t     s_out_q;
  coef_t     t_out_q;

  div_ctrl_t div_ctrl;
  word_t     rem;
  coef_t     prod_hi;
  coef_t     prod_lo;
  coef_t     s_raw;
  coef_t     s_adj;

  assign div_ctrl.start = (state_q == ST_CHECK) && (lo_q != '0);

  egcd_divmac u_divmac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctrl.start),
    .dividend_i (hi_q),
    .divisor_i  (lo_q),
    .coef_hi_i  (hc_q),
    .coef_lo_i  (lc_q),
    .done_o     (div_ctrl.done),
    .rem_o      (rem),
    .prod_hi_o  (prod_hi),
    .prod_lo_o  (prod_lo)
  );

  assign s_raw = swapped_q ? lp_q : hp_q;
  assign s_adj = s_raw[CW-1] ? (s_raw + {1'b0, b_q}) : s_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_q <= (lo_q == '0) ? ST_FINISH : ST_DIV;
        end
        ST_DIV: begin
          if (div_ctrl.done) begin
            state_q <= ST_CHECK;
          end
        end
        ST_FINISH: begin
          valid_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      b_q <= second_value_i;
      hp_q <= coef_t'(1);
      hc_q <= '0;
      lp_q <= '0;
      lc_q <= coef_t'(1);
      // Ties put the second operand first.
      if (first_value_i > second_value_i) begin
        hi_q      <= first_value_i;
        lo_q      <= second_value_i;
        swapped_q <= 1'b0;
      end else begin
        hi_q      <= second_value_i;
        lo_q      <= first_value_i;
        swapped_q <= 1'b1;
      end
    end else if (state_q == ST_DIV && div_ctrl.done) begin
      hi_q <= lo_q;
      lo_q <= rem;
      hp_q <= hc_q;
      hc_q <= hp_q - prod_hi;
      lp_q <= lc_q;
      lc_q <= lp_q - prod_lo;
    end
    if (state_q == ST_FINISH) begin
      g_q     <= hi_q;
      s_out_q <= s_adj[WIDTH-1:0];
      t_out_q <= swapped_q ? hp_q : lp_q;
    end
  end

  assign busy                 = (state_q != ST_IDLE);
  assign valid_o              = valid_q;
  assign divisor_o            = g_q;
  assign first_coefficient_o  = s_out_q;
  assign second_coefficient_o = $signed(t_out_q);

  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held longer than one cycle");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_valid_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == ST_IDLE)) else $error("result strobe outside idle");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.done |-> (state_q == ST_DIV)) else $error("divide done outside divide state");

endmodule

>>> sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  typedef struct {
    word_t divisor;
    word_t first_coef;
    coef_t second_coef;
  } bezout_t;

  class egcd_scoreboard;
    bezout_t expected_results[$];
    int      mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    // Extended Euclid on 64-bit words, with coefficient updates wrapping mod 2^64.
    function bezout_t bezout_of(word_t a, word_t b);
      bit [63:0] hi, lo, quo, rem, nxt;
      bit [63:0] hi_prev, hi_cur, lo_prev, lo_cur, s_coef, t_coef;
      bit        swapped;
      bezout_t   res;
      hi_prev = 64'd1;
      hi_cur  = 64'd0;
      lo_prev = 64'd0;
      lo_cur  = 64'd1;
      if (a > b) begin
        hi = {32'd0, a};
        lo = {32'd0, b};
        swapped = 1'b0;
      end else begin
        hi = {32'd0, b};
        lo = {32'd0, a};
        swapped = 1'b1;
      end
      while (lo != 64'd0) begin
        quo = hi / lo;
        rem = hi % lo;
        hi  = lo;
        lo  = rem;
        nxt = hi_prev - quo * hi_cur;
        hi_prev = hi_cur;
        hi_cur  = nxt;
        nxt = lo_prev - quo * lo_cur;
        lo_prev = lo_cur;
        lo_cur  = nxt;
      end
      s_coef = swapped ? lo_prev : hi_prev;
      t_coef = swapped ? hi_prev : lo_prev;
      // A negative coefficient for a is lifted into [0, b).
      if (s_coef[63]) begin
        s_coef = s_coef + {32'd0, b};
      end
      res.divisor     = hi[WIDTH-1:0];
      res.first_coef  = s_coef[WIDTH-1:0];
      res.second_coef = t_coef[CW-1:0];
      return res;
    endfunction

    function void note_operands(word_t a, word_t b);
      expected_results.push_back(bezout_of(a, b));
    endfunction

    function void report_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, name, exp_val,
                 act_val);
      end
    endfunction

    function void check_result(word_t g, word_t s, coef_t t);
      bezout_t exp_res;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("[%0t] result with nothing pending: %h %h %h", $realtime, g, s, t);
        end
        return;
      end
      exp_res = expected_results.pop_front();
      if (g !== exp_res.divisor) begin
        report_field("divisor", 64'(exp_res.divisor), 64'(g));
      end
      if (s !== exp_res.first_coef) begin
        report_field("first_coefficient", 64'(exp_res.first_coef), 64'(s));
      end
      if (t !== exp_res.second_coef) begin
        report_field("second_coefficient", 64'(exp_res.second_coef), 64'(t));
      end
    endfunction
  endclass

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  word_t first_value_i;
  word_t second_value_i;
  logic  valid_o;
  word_t divisor_o;
  word_t first_coefficient_o;
  logic signed [CW-1:0] second_coefficient_o;

  egcd_scoreboard sb;
  bit             burst_mode;

  extended_gcd_modular_inverse_core dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .first_value_i        (first_value_i),
    .second_value_i       (second_value_i),
    .valid_o              (valid_o),
    .divisor_o            (divisor_o),
    .first_coefficient_o  (first_coefficient_o),
    .second_coefficient_o (second_coefficient_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial sb = new();

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      sb.note_operands(first_value_i, second_value_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_result(divisor_o, first_coefficient_o, second_coefficient_o);
    end
  end

  // Called right after a rising edge; returns at the edge that accepts the transaction.
  task automatic send_operands(word_t a, word_t b, int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    first_value_i  = a;
    second_value_i = b;
    start          = 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned draw_gap();
    if (burst_mode) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic word_t low_bits(word_t v, int unsigned bits);
    if (bits >= WIDTH) begin
      return v;
    end
    return v & ((word_t'(1) << bits) - word_t'(1));
  endfunction

  task automatic send_random_pair();
    word_t       a, b, g;
    bit   [63:0] fib_lo, fib_hi, fib_nx;
    int unsigned kind, n;
    kind = $urandom_range(0, 9);
    a = $urandom();
    b = $urandom();
    case (kind)
      4: begin
        a = low_bits(a, $urandom_range(1, 8));
        b = low_bits(b, $urandom_range(1, 8));
      end
      5: begin
        // Shared factor g in [1, 65535], so the gcd is a multiple of g.
        g = $urandom_range(1, 65535);
        a = g * word_t'($urandom_range(0, 32'hFFFF_FFFF / g));
        b = g * word_t'($urandom_range(0, 32'hFFFF_FFFF / g));
      end
      6: begin
        case ($urandom_range(0, 2))
          0: a = 0;
          1: b = 0;
          default: a = b;
        endcase
      end
      7: begin
        // Consecutive Fibonacci numbers take the longest chain of steps.
        fib_lo = 64'd1;
        fib_hi = 64'd1;
        n = $urandom_range(1, 45);
        repeat (n) begin
          fib_nx = fib_lo + fib_hi;
          fib_lo = fib_hi;
          fib_hi = fib_nx;
        end
        if ($urandom_range(0, 1) != 0) begin
          a = fib_lo[WIDTH-1:0];
          b = fib_hi[WIDTH-1:0];
        end else begin
          a = fib_hi[WIDTH-1:0];
          b = fib_lo[WIDTH-1:0];
        end
      end
      8: begin
        a = low_bits(a, $urandom_range(1, WIDTH));
        b = low_bits(b, $urandom_range(1, WIDTH));
      end
      9: begin
        // Typical inverse request: odd modulus, operand below it.
        b = b | word_t'(1);
        a = (b > 1) ? word_t'($urandom_range(1, b - 1)) : word_t'(0);
      end
      default: begin
      end
    endcase
    send_operands(a, b, draw_gap());
  endtask

  initial begin
    word_t dir_a[$];
    word_t dir_b[$];
    rst_ni         = 1'b0;
    start          = 1'b0;
    first_value_i  = '0;
    second_value_i = '0;
    burst_mode     = 1'b0;
    dir_a = '{32'd0, 32'd0, 32'd5, 32'd1, 32'd0, 32'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd3, 32'd7,
              32'd6, 32'd12, 32'd1, 32'h8000_0000, 32'd2971215073, 32'd1836311903,
              32'hFFFF_FFFB, 32'd17};
    dir_b = '{32'd0, 32'd5, 32'd0, 32'd0, 32'd1, 32'd7, 32'hFFFF_FFFF, 32'd0,
              32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd7,
              32'd3, 32'd4, 32'd18, 32'd1, 32'hFFFF_FFFF, 32'd1836311903, 32'd2971215073,
              32'd17, 32'hFFFF_FFFB};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    foreach (dir_a[i]) begin
      send_operands(dir_a[i], dir_b[i], (i % 3 == 0) ? 0 : $urandom_range(0, 12));
    end
    @(negedge clk_i);
    start = 1'b0;
    wait_drained();

    for (int i = 0; i < 300; i++) begin
      if (i % 20 == 0) begin
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      if (i == 150) begin
        @(negedge clk_i);
        start = 1'b0;
        wait_drained();
      end
      send_random_pair();
    end
    @(negedge clk_i);
    start = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
